// ----- hdl/dcf_pkg.sv -----
`default_nettype none

package dcf_pkg;

    localparam int DCF_TRIES = 4;
    localparam int DCF_DN_W = 18;
    localparam int DCF_YR_W = 9;
    localparam int DCF_DOY_W = 9;
    localparam int DCF_TS_W = 34;
    localparam int DCF_PROD_W = 35;

    localparam logic [5:0] DCF_MIN_BITS = 6'd59;
    localparam logic [5:0] DCF_LEAP_BITS = 6'd60;
    localparam logic [6:0] DCF_PIVOT = 7'd5;
    localparam logic [DCF_YR_W-1:0] DCF_CENTURY = 9'd100;
    localparam logic [DCF_DN_W-1:0] DCF_DAY_2000_03_01 = 18'd11017;
    localparam logic [DCF_DN_W-1:0] DCF_DAYS_PER_YEAR = 18'd365;
    localparam logic [DCF_PROD_W-1:0] DCF_SECS_PER_DAY = 35'd86400;
    localparam logic [16:0] DCF_SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] DCF_SECS_PER_MIN = 17'd60;

    typedef struct packed {
        logic       ok;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [1:0] offs;
    } dcf_time_t;

    typedef struct packed {
        dcf_time_t  tod;
        logic [5:0] day;
        logic [2:0] wday;
        logic [3:0] month;
        logic [6:0] yoc;
    } dcf_fields_t;

    typedef struct packed {
        dcf_time_t             tod;
        logic [DCF_DN_W-1:0]   dn;
    } dcf_date_t;

    // first day of month counted from march, (153 * mp + 2) / 5
    function automatic logic [DCF_DOY_W-1:0] dcf_month_start(input logic [3:0] mp);
        logic [DCF_DOY_W-1:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // residue mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] dcf_mod7(input logic [DCF_DN_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
           + 6'(x[14:12]) + 6'(x[17:15]);
        s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7)
        begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dcf_decode.sv -----
`default_nettype none

module dcf_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [59:0]         frame_bits,
    input  wire logic [5:0]          bit_count,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output dcf_pkg::dcf_fields_t     out_fields
);
    import dcf_pkg::*;

    logic        valid_reg;
    dcf_fields_t fields_reg;
    dcf_fields_t fields_next;
    logic        frame_ok;
    logic [5:0]  minute;
    logic [5:0]  hour;
    logic [5:0]  day;
    logic [4:0]  month;
    logic [7:0]  yoc;

    always_comb
    begin
        minute = 6'(frame_bits[24:21]) + 6'(frame_bits[27:25]) * 6'd10;
        hour   = 6'(frame_bits[32:29]) + 6'(frame_bits[34:33]) * 6'd10;
        day    = 6'(frame_bits[39:36]) + 6'(frame_bits[41:40]) * 6'd10;
        month  = 5'(frame_bits[48:45]) + (frame_bits[49] ? 5'd10 : 5'd0);
        yoc    = 8'(frame_bits[53:50]) + 8'(frame_bits[57:54]) * 8'd10;

        frame_ok = (bit_count == DCF_MIN_BITS || bit_count == DCF_LEAP_BITS)
                 && !(bit_count == DCF_LEAP_BITS && frame_bits[59])
                 && !frame_bits[0] && frame_bits[20]
                 && !(^frame_bits[28:21]) && !(^frame_bits[35:29])
                 && !(^frame_bits[58:36])
                 && frame_bits[24:21] < 4'd10 && frame_bits[27:25] < 3'd6
                 && frame_bits[32:29] < 4'd10 && hour < 6'd24
                 && frame_bits[39:36] < 4'd10 && day != 6'd0
                 && frame_bits[44:42] != 3'd0
                 && frame_bits[48:45] < 4'd10 && month != 5'd0 && month <= 5'd12
                 && frame_bits[53:50] < 4'd10 && frame_bits[57:54] < 4'd10;

        fields_next.tod.ok     = frame_ok;
        fields_next.tod.minute = minute;
        fields_next.tod.hour   = hour[4:0];
        fields_next.tod.offs   = {frame_bits[17], frame_bits[18]};
        fields_next.day        = day;
        fields_next.wday       = frame_bits[44:42];
        fields_next.month      = month[3:0];
        fields_next.yoc        = yoc[6:0];
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_fields = fields_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fields_reg <= fields_next;
        end
    end

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && fields_reg.tod.ok |->
            fields_reg.tod.minute < 6'd60 && fields_reg.tod.hour < 5'd24
            && fields_reg.month != 4'd0 && fields_reg.month <= 4'd12
            && fields_reg.yoc < 7'd100)
        else $error("decoded field out of range");

endmodule

`default_nettype wire

// ----- hdl/dcf_calendar.sv -----
`default_nettype none

module dcf_calendar (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire dcf_pkg::dcf_fields_t in_fields,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output dcf_pkg::dcf_date_t       out_date
);
    import dcf_pkg::*;

    // stage a: years of each century try and day of year
    logic                 a_valid_reg;
    logic                 a_ready;
    dcf_time_t            a_tod_reg;
    logic [2:0]           a_wday_reg;
    logic [DCF_DOY_W-1:0] a_doy_reg;
    logic [DCF_YR_W-1:0]  a_yr_reg [DCF_TRIES];
    logic [DCF_DOY_W-1:0] a_doy_next;
    logic [DCF_YR_W-1:0]  a_yr_next [DCF_TRIES];
    logic [DCF_YR_W-1:0]  base_yr;
    logic [3:0]           mp;

    // stage b: day number of each try
    logic                 b_valid_reg;
    logic                 b_ready;
    dcf_time_t            b_tod_reg;
    logic [2:0]           b_wday_reg;
    logic [DCF_DN_W-1:0]  b_dn_reg [DCF_TRIES];
    logic [DCF_DN_W-1:0]  b_dn_next [DCF_TRIES];

    // stage c: first try whose weekday matches
    logic                 c_valid_reg;
    logic                 c_ready;
    dcf_date_t            c_date_reg;
    dcf_date_t            c_date_next;

    always_comb
    begin
        if (in_fields.yoc < DCF_PIVOT)
        begin
            base_yr = 9'(in_fields.yoc) + DCF_CENTURY;
        end
        else
        begin
            base_yr = 9'(in_fields.yoc);
        end
        if (in_fields.month <= 4'd2)
        begin
            base_yr = base_yr - 9'd1;
            mp      = in_fields.month + 4'd9;
        end
        else
        begin
            mp      = in_fields.month - 4'd3;
        end
        a_doy_next = dcf_month_start(mp) + 9'(in_fields.day) - 9'd1;
        for (int k = 0; k < DCF_TRIES; k++)
        begin
            a_yr_next[k] = base_yr + 9'(k) * DCF_CENTURY;
        end
    end

    always_comb
    begin
        logic [DCF_DN_W-1:0] y;
        logic [DCF_DN_W-1:0] c100;
        for (int k = 0; k < DCF_TRIES; k++)
        begin
            y = 18'(a_yr_reg[k]);
            if (y >= 18'd400)
            begin
                c100 = 18'd4;
            end
            else if (y >= 18'd300)
            begin
                c100 = 18'd3;
            end
            else if (y >= 18'd200)
            begin
                c100 = 18'd2;
            end
            else if (y >= 18'd100)
            begin
                c100 = 18'd1;
            end
            else
            begin
                c100 = 18'd0;
            end
            b_dn_next[k] = y * DCF_DAYS_PER_YEAR + (y >> 2) - c100
                         + ((y >= 18'd400) ? 18'd1 : 18'd0)
                         + 18'(a_doy_reg) + DCF_DAY_2000_03_01;
        end
    end

    always_comb
    begin
        logic hit;
        hit = 1'b0;
        c_date_next.tod = b_tod_reg;
        c_date_next.dn  = b_dn_reg[0];
        for (int k = DCF_TRIES - 1; k >= 0; k--)
        begin
            if (dcf_mod7(b_dn_reg[k] + 18'd3) == b_wday_reg - 3'd1)
            begin
                hit            = 1'b1;
                c_date_next.dn = b_dn_reg[k];
            end
        end
        c_date_next.tod.ok = b_tod_reg.ok && hit;
    end

    assign c_ready   = !c_valid_reg || out_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = c_valid_reg;
    assign out_date  = c_date_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_tod_reg  <= in_fields.tod;
            a_wday_reg <= in_fields.wday;
            a_doy_reg  <= a_doy_next;
            a_yr_reg   <= a_yr_next;
        end
        if (a_valid_reg && b_ready)
        begin
            b_tod_reg  <= a_tod_reg;
            b_wday_reg <= a_wday_reg;
            b_dn_reg   <= b_dn_next;
        end
        if (b_valid_reg && c_ready)
        begin
            c_date_reg <= c_date_next;
        end
    end

    a_min_day: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg && c_date_reg.tod.ok |-> c_date_reg.dn >= 18'd12784)
        else $error("accepted date before 2005");

    a_century_step: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> a_yr_reg[1] == a_yr_reg[0] + DCF_CENTURY)
        else $error("century tries not spaced by one century");

endmodule

`default_nettype wire

// ----- hdl/dcf_stamp.sv -----
`default_nettype none

module dcf_stamp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire dcf_pkg::dcf_date_t   in_date,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      frame_valid,
    output logic [dcf_pkg::DCF_TS_W-1:0] utc_seconds
);
    import dcf_pkg::*;

    logic                  p_valid_reg;
    logic                  p_ready;
    logic                  p_ok_reg;
    logic [DCF_PROD_W-1:0] p_prod_reg;
    logic [16:0]           p_tod_reg;
    logic [16:0]           p_offs_reg;
    logic                  o_valid_reg;
    logic                  o_ok_reg;
    logic [DCF_TS_W-1:0]   o_ts_reg;
    logic [DCF_PROD_W-1:0] ts_sum;

    assign ts_sum = p_prod_reg + 35'(p_tod_reg) - 35'(p_offs_reg);

    assign p_ready     = !o_valid_reg || out_ready;
    assign in_ready    = !p_valid_reg || p_ready;
    assign out_valid   = o_valid_reg;
    assign frame_valid = o_ok_reg;
    assign utc_seconds = o_ts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                p_valid_reg <= in_valid;
            end
            if (p_ready)
            begin
                o_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            p_ok_reg   <= in_date.tod.ok;
            p_prod_reg <= 35'(in_date.dn) * DCF_SECS_PER_DAY;
            p_tod_reg  <= 17'(in_date.tod.hour) * DCF_SECS_PER_HOUR
                        + 17'(in_date.tod.minute) * DCF_SECS_PER_MIN;
            p_offs_reg <= 17'(in_date.tod.offs) * DCF_SECS_PER_HOUR;
        end
        if (p_valid_reg && p_ready)
        begin
            o_ok_reg <= p_ok_reg;
            o_ts_reg <= p_ok_reg ? ts_sum[DCF_TS_W-1:0] : '0;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dcf77_frame_decoder_top.sv -----
// dcf77 minute frame decoder
// input stream: one transaction per received minute frame, s_axis_tdata holds
//   the 60 frame bits (bit i = second i) and the 6-bit count of seconds seen
// output stream: one transaction per input transaction, in order;
//   m_axis_tuser is 1 when the frame passed every check, m_axis_tdata holds
//   the utc unix seconds of the decoded minute, zero for a rejected frame
// checks: count, leap slot, start and time markers, parity, bcd digits,
//   field ranges and weekday match over up to four centuries from 2005
// pipeline: six register stages, one each for field decode, century years,
//   day numbers, weekday select, the day-to-seconds multiply and the final
//   sum
// throughput: one frame per cycle unless stalled; every stage has its own valid bit
// stall: a stage holds while the one after it is full and stalled, so the
//   pipeline keeps taking frames until all six stages are occupied, and
//   s_axis_tready falls only then
// reset: all stage valid bits clear, nothing is pending, s_axis_tready is high
`default_nettype none

module dcf77_frame_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // frame_bits[59:0], bit_count[65:60], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // utc_seconds[33:0], zero pad
    output logic [0:0]       m_axis_tuser    // frame_valid
);
    import dcf_pkg::*;

    logic                dec_valid;
    logic                dec_ready;
    dcf_fields_t         dec_fields;
    logic                cal_valid;
    logic                cal_ready;
    dcf_date_t           cal_date;
    logic                frame_valid;
    logic [DCF_TS_W-1:0] utc_seconds;

    dcf_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .frame_bits (s_axis_tdata[59:0]),
        .bit_count  (s_axis_tdata[65:60]),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_fields (dec_fields)
    );

    dcf_calendar u_calendar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_fields (dec_fields),
        .out_valid (cal_valid),
        .out_ready (cal_ready),
        .out_date  (cal_date)
    );

    dcf_stamp u_stamp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cal_valid),
        .in_ready    (cal_ready),
        .in_date     (cal_date),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .frame_valid (frame_valid),
        .utc_seconds (utc_seconds)
    );

    assign m_axis_tdata = {6'd0, utc_seconds};
    assign m_axis_tuser = frame_valid;

    a_zero_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
        else $error("rejected frame with nonzero timestamp");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked while output side is free");

endmodule

`default_nettype wire
